// ===== rtl/ibcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image blit package
// Shared types, register indexes, pixel formats and reset values for the
// framebuffer blit with clipping.
// ----------------------------------------------------------------------------
package ibcf_pkg;

  localparam int unsigned MaxImageDimDef  = 4096;
  localparam int unsigned MaxScreenDimDef = 256;
  localparam int unsigned QueueDepth      = 4;

  localparam logic [31:0] FrameBaseRst    = 32'hF000_0014;
  localparam logic [8:0]  ScreenWidthRst  = 9'd128;
  localparam logic [8:0]  ScreenHeightRst = 9'd64;
  localparam logic [12:0] ImageWidthRst   = 13'd1;
  localparam logic [12:0] ImageHeightRst  = 13'd1;
  localparam logic [3:0]  BppRst          = 4'd3;
  localparam logic [12:0] DestRst         = 13'd0;

  localparam logic [3:0] BppGray = 4'd1;
  localparam logic [3:0] BppRgb  = 4'd3;
  localparam logic [3:0] BppRgba = 4'd4;

  typedef enum logic [2:0] {
    RegFrameBase    = 3'd0,
    RegScreenWidth  = 3'd1,
    RegScreenHeight = 3'd2,
    RegImageWidth   = 3'd3,
    RegImageHeight  = 3'd4,
    RegBytesPerPix  = 3'd5,
    RegDestX        = 3'd6,
    RegDestY        = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    SlotRed   = 2'd0,
    SlotGreen = 2'd1,
    SlotBlue  = 2'd2,
    SlotAlpha = 2'd3
  } slot_e;

  typedef struct packed {
    logic [31:0] frame_base;
    logic [8:0]  screen_width;
    logic [8:0]  screen_height;
    logic [12:0] pic_width;
    logic [12:0] pic_height;
    logic [3:0]  bytes_per_pixel;
    logic [12:0] dest_x;
    logic [12:0] dest_y;
  } cfg_t;

endpackage

// ===== rtl/image_blit_clip_to_framebuffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image blit with clipping, top level
// Configuration registers, the pixel front end, the request queue and the
// framebuffer address pipeline.
//
//   Channel  Direction  Handshake           Payload
//   in       sink       in_valid / stall    image_byte
//   out      source     out_valid / stall   write_address, pixel_color
//   cfg      sink       cfg_valid / ready   cfg_index, cfg_data
//
// One byte is taken every cycle while the four-entry request queue has room.
// A pixel write passes through the queue, the multiply stage and the output
// register after its last byte. Reset loads the register defaults and clears the
// counters. An output stall fills the queue and then stalls the input.
// ----------------------------------------------------------------------------
module image_blit_clip_to_framebuffer_top #(
  parameter int unsigned MAX_IMAGE_DIM  = ibcf_pkg::MaxImageDimDef,
  parameter int unsigned MAX_SCREEN_DIM = ibcf_pkg::MaxScreenDimDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  image_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] write_address_o,
  output logic [23:0] pixel_color_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned SW0 = $clog2(MAX_SCREEN_DIM + 1);
  localparam int unsigned SWW = (SW0 > 9) ? SW0 : 9;
  localparam int unsigned PW  = $clog2(MAX_SCREEN_DIM);
  localparam int unsigned QW  = 2 * PW + 24;

  ibcf_pkg::cfg_t  cfg_q;
  logic [SWW-1:0]  sw;
  logic            push, full, pop, head_valid;
  logic [PW-1:0]   push_x, push_y;
  logic [23:0]     push_color;
  logic [QW-1:0]   head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base      <= ibcf_pkg::FrameBaseRst;
      cfg_q.screen_width    <= ibcf_pkg::ScreenWidthRst;
      cfg_q.screen_height   <= ibcf_pkg::ScreenHeightRst;
      cfg_q.pic_width       <= ibcf_pkg::ImageWidthRst;
      cfg_q.pic_height      <= ibcf_pkg::ImageHeightRst;
      cfg_q.bytes_per_pixel <= ibcf_pkg::BppRst;
      cfg_q.dest_x          <= ibcf_pkg::DestRst;
      cfg_q.dest_y          <= ibcf_pkg::DestRst;
    end else if (cfg_valid_i) begin
      unique case (ibcf_pkg::reg_idx_e'(cfg_index_i))
        ibcf_pkg::RegFrameBase:    cfg_q.frame_base      <= cfg_data_i;
        ibcf_pkg::RegScreenWidth:  cfg_q.screen_width    <= cfg_data_i[8:0];
        ibcf_pkg::RegScreenHeight: cfg_q.screen_height   <= cfg_data_i[8:0];
        ibcf_pkg::RegImageWidth:   cfg_q.pic_width       <= cfg_data_i[12:0];
        ibcf_pkg::RegImageHeight:  cfg_q.pic_height      <= cfg_data_i[12:0];
        ibcf_pkg::RegBytesPerPix:  cfg_q.bytes_per_pixel <= cfg_data_i[3:0];
        ibcf_pkg::RegDestX:        cfg_q.dest_x          <= cfg_data_i[12:0];
        ibcf_pkg::RegDestY:        cfg_q.dest_y          <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_q.screen_width == 9'd0) sw = SWW'(1);
    else if (SWW'(cfg_q.screen_width) > SWW'(MAX_SCREEN_DIM)) sw = SWW'(MAX_SCREEN_DIM);
    else sw = SWW'(cfg_q.screen_width);
  end

  ibcf_front #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
    .MAX_SCREEN_DIM(MAX_SCREEN_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sw_i        (sw),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .image_byte_i(image_byte_i),
    .full_i      (full),
    .push_o      (push),
    .push_x_o    (push_x),
    .push_y_o    (push_y),
    .push_color_o(push_color)
  );

  ibcf_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_y, push_x, push_color}),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head)
  );

  ibcf_back #(
    .MAX_SCREEN_DIM(MAX_SCREEN_DIM)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_base_i   (cfg_q.frame_base),
    .sw_i           (sw),
    .head_valid_i   (head_valid),
    .head_x_i       (head[PW+23:24]),
    .head_y_i       (head[QW-1:PW+24]),
    .head_color_i   (head[23:0]),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_address_o(write_address_o),
    .pixel_color_o  (pixel_color_o)
  );

endmodule

// ===== rtl/ibcf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image blit front end
// Gathers bytes into pixels, walks the image counters and clips each pixel
// against the screen; on-screen pixels are pushed into the request queue.
// ----------------------------------------------------------------------------
module ibcf_front #(
  parameter int unsigned MAX_IMAGE_DIM  = ibcf_pkg::MaxImageDimDef,
  parameter int unsigned MAX_SCREEN_DIM = ibcf_pkg::MaxScreenDimDef,
  localparam int unsigned CW  = $clog2(MAX_IMAGE_DIM),
  localparam int unsigned IW0 = $clog2(MAX_IMAGE_DIM + 1),
  localparam int unsigned IW  = (IW0 > 13) ? IW0 : 13,
  localparam int unsigned SW0 = $clog2(MAX_SCREEN_DIM + 1),
  localparam int unsigned SWW = (SW0 > 9) ? SW0 : 9,
  localparam int unsigned PW  = $clog2(MAX_SCREEN_DIM),
  localparam int unsigned XW  = ((CW > 13) ? CW : 13) + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ibcf_pkg::cfg_t     cfg_i,
  input  logic [SWW-1:0]     sw_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         image_byte_i,
  input  logic               full_i,
  output logic               push_o,
  output logic [PW-1:0]      push_x_o,
  output logic [PW-1:0]      push_y_o,
  output logic [23:0]        push_color_o
);

  logic [CW-1:0]         col_q, col_d, row_q, row_d;
  ibcf_pkg::slot_e       slot_q, slot_d;
  logic [7:0]            red_q, red_d, green_q, green_d;
  logic                  accept, emit, end_px, on_screen;
  logic [IW-1:0]         iw, ih, col_inc, row_inc;
  logic [SWW-1:0]        sh;
  logic signed [XW-1:0]  x, y;
  logic [23:0]           color;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  always_comb begin
    if (cfg_i.pic_width == 13'd0) iw = IW'(1);
    else if (IW'(cfg_i.pic_width) > IW'(MAX_IMAGE_DIM)) iw = IW'(MAX_IMAGE_DIM);
    else iw = IW'(cfg_i.pic_width);
    if (cfg_i.pic_height == 13'd0) ih = IW'(1);
    else if (IW'(cfg_i.pic_height) > IW'(MAX_IMAGE_DIM)) ih = IW'(MAX_IMAGE_DIM);
    else ih = IW'(cfg_i.pic_height);
    if (cfg_i.screen_height == 9'd0) sh = SWW'(1);
    else if (SWW'(cfg_i.screen_height) > SWW'(MAX_SCREEN_DIM)) sh = SWW'(MAX_SCREEN_DIM);
    else sh = SWW'(cfg_i.screen_height);
  end

  assign x = {{(XW-13){cfg_i.dest_x[12]}}, cfg_i.dest_x} + {{(XW-CW){1'b0}}, col_q};
  assign y = {{(XW-13){cfg_i.dest_y[12]}}, cfg_i.dest_y} + {{(XW-CW){1'b0}}, row_q};

  assign on_screen = ~x[XW-1] && ~y[XW-1]
                     && (x[XW-2:0] < (XW-1)'(sw_i)) && (y[XW-2:0] < (XW-1)'(sh));

  assign col_inc = IW'(col_q) + IW'(1);
  assign row_inc = IW'(row_q) + IW'(1);

  always_comb begin
    slot_d  = slot_q;
    red_d   = red_q;
    green_d = green_q;
    emit    = 1'b0;
    end_px  = 1'b0;
    color   = {red_q, green_q, image_byte_i};
    if (cfg_i.bytes_per_pixel == ibcf_pkg::BppGray) begin
      emit   = 1'b1;
      end_px = 1'b1;
      color  = {image_byte_i, image_byte_i, image_byte_i};
    end else if (cfg_i.bytes_per_pixel == ibcf_pkg::BppRgb
                 || cfg_i.bytes_per_pixel == ibcf_pkg::BppRgba) begin
      if (slot_q == ibcf_pkg::SlotRed) begin
        red_d  = image_byte_i;
        slot_d = ibcf_pkg::SlotGreen;
      end else if (slot_q == ibcf_pkg::SlotGreen) begin
        green_d = image_byte_i;
        slot_d  = ibcf_pkg::SlotBlue;
      end else if (slot_q == ibcf_pkg::SlotBlue
                   || cfg_i.bytes_per_pixel == ibcf_pkg::BppRgb) begin
        emit = 1'b1;
        if (cfg_i.bytes_per_pixel == ibcf_pkg::BppRgb) begin
          end_px = 1'b1;
        end else begin
          slot_d = ibcf_pkg::SlotAlpha;
        end
      end else begin
        end_px = 1'b1;
      end
    end
    col_d = col_q;
    row_d = row_q;
    if (end_px) begin
      slot_d = ibcf_pkg::SlotRed;
      if (col_inc >= iw) begin
        col_d = '0;
        row_d = (row_inc >= ih) ? '0 : row_inc[CW-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      slot_q  <= ibcf_pkg::SlotRed;
      red_q   <= '0;
      green_q <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      slot_q  <= slot_d;
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

  assign push_o       = accept & emit & on_screen;
  assign push_x_o     = x[PW-1:0];
  assign push_y_o     = y[PW-1:0];
  assign push_color_o = color;

endmodule

// ===== rtl/ibcf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image blit request queue
// Small first-in first-out buffer that decouples the front end from the
// address pipeline.
// ----------------------------------------------------------------------------
module ibcf_queue #(
  parameter int unsigned WIDTH = 8,
  localparam int unsigned Depth = ibcf_pkg::QueueDepth,
  localparam int unsigned AW    = $clog2(Depth),
  localparam int unsigned NW    = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    cnt_q;

  assign full_o  = (cnt_q == NW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

// ===== rtl/ibcf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image blit back end
// Two-stage address pipeline: row times stride, then base plus word offset,
// ending in the output register.
// ----------------------------------------------------------------------------
module ibcf_back #(
  parameter int unsigned MAX_SCREEN_DIM = ibcf_pkg::MaxScreenDimDef,
  localparam int unsigned SW0 = $clog2(MAX_SCREEN_DIM + 1),
  localparam int unsigned SWW = (SW0 > 9) ? SW0 : 9,
  localparam int unsigned PW  = $clog2(MAX_SCREEN_DIM),
  localparam int unsigned PRW = PW + SWW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    frame_base_i,
  input  logic [SWW-1:0] sw_i,
  input  logic           head_valid_i,
  input  logic [PW-1:0]  head_x_i,
  input  logic [PW-1:0]  head_y_i,
  input  logic [23:0]    head_color_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    write_address_o,
  output logic [23:0]    pixel_color_o
);

  logic           s1_valid_q, out_valid_q;
  logic [PRW-1:0] prod_q;
  logic [PW-1:0]  x_q;
  logic [23:0]    s1_color_q, out_color_q;
  logic [31:0]    addr_q;
  logic [PRW:0]   word;
  logic           out_free, s1_adv, s1_load;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign s1_adv   = s1_valid_q & out_free;
  assign s1_load  = ~s1_valid_q | s1_adv;
  assign pop_o    = head_valid_i & s1_load;
  assign word     = (PRW+1)'(prod_q) + (PRW+1)'(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= head_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q     <= PRW'(head_y_i) * PRW'(sw_i);
      x_q        <= head_x_i;
      s1_color_q <= head_color_i;
    end
    if (s1_adv) begin
      addr_q      <= frame_base_i + 32'({word, 2'b00});
      out_color_q <= s1_color_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = addr_q;
  assign pixel_color_o   = out_color_q;

endmodule
